// ===== sv/rtwe_pkg.sv =====
`default_nettype none

package rtwe_pkg;

    // defaults for the top level parameters
    localparam int MAX_ROUTE_STOPS_DEF = 256;
    localparam int FRAC_BITS_DEF       = 8;

    // fixed field widths
    localparam int COORD_W   = 12;
    localparam int FIELD_W   = 16;
    localparam int TIME_W    = 40;
    localparam int DIST_W    = 32;
    localparam int DEM_W     = 24;
    localparam int COUNT_W   = 8;

    // integer bits of a leg length: sqrt(2) * 4095 < 2^13
    localparam int LEG_INT_W = COORD_W + 1;

    // start and end depot are not customers
    localparam int DEPOT_STOPS = 2;

    // entries in the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;

    // one classified stop handed from front to back
    typedef struct packed {
        logic               first;
        logic               last;
        logic [FIELD_W-1:0] demand;
        logic [FIELD_W-1:0] ready_time;
        logic [FIELD_W-1:0] due_time;
        logic [FIELD_W-1:0] service_duration;
    } stop_t;

    localparam int STOP_W = $bits(stop_t);

endpackage

`default_nettype wire

// ===== sv/rtwe_isqrt.sv =====
`default_nettype none

module rtwe_isqrt #(
    parameter int ROOT_W = rtwe_pkg::LEG_INT_W + rtwe_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 2;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [2*ROOT_W-1:0] rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    trial;
    logic                fits;

    // one result bit per cycle, two radicand bits brought down each step
    assign rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

// ===== sv/rtwe_front.sv =====
`default_nettype none

module rtwe_front #(
    parameter int FRAC_BITS = rtwe_pkg::FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [rtwe_pkg::COORD_W-1:0]               x_coord,
    input  logic [rtwe_pkg::COORD_W-1:0]               y_coord,
    input  logic [rtwe_pkg::FIELD_W-1:0]               demand,
    input  logic [rtwe_pkg::FIELD_W-1:0]               ready_time,
    input  logic [rtwe_pkg::FIELD_W-1:0]               due_time,
    input  logic [rtwe_pkg::FIELD_W-1:0]               service_duration,
    input  logic                                       last_stop,
    output logic                                       q_push,
    input  logic                                       q_full,
    output rtwe_pkg::stop_t                            q_stop,
    output logic [rtwe_pkg::LEG_INT_W+FRAC_BITS-1:0]   q_leg
);

    localparam int COORD_W = rtwe_pkg::COORD_W;
    localparam int LEG_W   = rtwe_pkg::LEG_INT_W + FRAC_BITS;
    localparam int RAD_W   = 2 * LEG_W;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SQ_W    = PROD_W + 1;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_ROOT = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t        state_reg;
    front_state_t        state_next;
    logic                in_route_reg;
    logic [COORD_W-1:0]  prev_x_reg;
    logic [COORD_W-1:0]  prev_y_reg;
    logic [COORD_W-1:0]  dx_reg;
    logic [COORD_W-1:0]  dy_reg;
    rtwe_pkg::stop_t     stop_reg;
    logic [LEG_W-1:0]    leg_reg;

    logic                accept;
    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic [PROD_W-1:0]   sq_x;
    logic [PROD_W-1:0]   sq_y;
    logic [SQ_W-1:0]     sq_sum;
    logic [RAD_W-1:0]    radicand;
    logic                root_start;
    logic                root_done;
    logic [LEG_W-1:0]    root;

    assign in_stall = (state_reg != F_IDLE);
    assign accept   = in_valid && (state_reg == F_IDLE);

    // absolute coordinate differences against the previous stop
    assign dx = (x_coord > prev_x_reg) ? (x_coord - prev_x_reg) : (prev_x_reg - x_coord);
    assign dy = (y_coord > prev_y_reg) ? (y_coord - prev_y_reg) : (prev_y_reg - y_coord);

    assign sq_x     = dx_reg * dx_reg;
    assign sq_y     = dy_reg * dy_reg;
    assign sq_sum   = {1'b0, sq_x} + {1'b0, sq_y};
    assign radicand = RAD_W'(sq_sum) << (2 * FRAC_BITS);

    assign root_start = (state_reg == F_MUL);

    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_stop = stop_reg;
    assign q_leg  = leg_reg;

    rtwe_isqrt #(
        .ROOT_W   (LEG_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    // a route's opening stop has no leg
                    state_next = in_route_reg ? F_MUL : F_PUSH;
                end
            end
            F_MUL:
            begin
                state_next = F_ROOT;
            end
            F_ROOT:
            begin
                if (root_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            in_route_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                in_route_reg <= !last_stop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_x_reg                <= x_coord;
            prev_y_reg                <= y_coord;
            dx_reg                    <= dx;
            dy_reg                    <= dy;
            stop_reg.first            <= !in_route_reg;
            stop_reg.last             <= last_stop;
            stop_reg.demand           <= demand;
            stop_reg.ready_time       <= ready_time;
            stop_reg.due_time         <= due_time;
            stop_reg.service_duration <= service_duration;
            leg_reg                   <= '0;
        end
        else if ((state_reg == F_ROOT) && root_done)
        begin
            leg_reg <= root;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rtwe_fifo.sv =====
`default_nettype none

module rtwe_fifo #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = rtwe_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign rd_data = entry_reg[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rtwe_back.sv =====
`default_nettype none

module rtwe_back #(
    parameter int MAX_ROUTE_STOPS = rtwe_pkg::MAX_ROUTE_STOPS_DEF,
    parameter int FRAC_BITS       = rtwe_pkg::FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       q_empty,
    output logic                                       q_pop,
    input  rtwe_pkg::stop_t                            item_stop,
    input  logic [rtwe_pkg::LEG_INT_W+FRAC_BITS-1:0]   item_leg,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic [rtwe_pkg::DIST_W-1:0]                route_length,
    output logic [rtwe_pkg::DEM_W-1:0]                 route_load,
    output logic [rtwe_pkg::DIST_W-1:0]                route_lateness,
    output logic [rtwe_pkg::COUNT_W-1:0]               customer_count,
    output logic                                       route_overflow
);

    localparam int TIME_W   = rtwe_pkg::TIME_W;
    localparam int TIME_X_W = TIME_W + 1;
    localparam int DIST_W   = rtwe_pkg::DIST_W;
    localparam int DIST_X_W = DIST_W + 1;
    localparam int DEM_W    = rtwe_pkg::DEM_W;
    localparam int DEM_X_W  = DEM_W + 1;
    localparam int COUNT_W  = rtwe_pkg::COUNT_W;
    localparam int LEG_W    = rtwe_pkg::LEG_INT_W + FRAC_BITS;
    localparam int CNT_W    = $clog2(MAX_ROUTE_STOPS + 2);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_TIME = 3'b010,
        B_SUM  = 3'b100
    } back_state_t;

    back_state_t          state_reg;
    back_state_t          state_next;
    rtwe_pkg::stop_t      stop_reg;
    logic [LEG_W-1:0]     leg_reg;
    logic [TIME_W-1:0]    prev_dep_reg;
    logic [TIME_W-1:0]    start_reg;
    logic [DIST_W-1:0]    dist_sum_reg;
    logic [DEM_W-1:0]     dem_sum_reg;
    logic [DIST_W-1:0]    late_sum_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 out_valid_reg;
    logic [DIST_W-1:0]    dist_out_reg;
    logic [DEM_W-1:0]     dem_out_reg;
    logic [DIST_W-1:0]    late_out_reg;
    logic [COUNT_W-1:0]   cust_out_reg;
    logic                 over_out_reg;

    logic [TIME_W-1:0]    ready_fx;
    logic [TIME_W-1:0]    due_fx;
    logic [TIME_W-1:0]    serv_fx;
    logic [TIME_W:0]      arrive_x;
    logic [TIME_W-1:0]    arrive;
    logic [TIME_W-1:0]    start_calc;
    logic [DIST_W:0]      dist_x;
    logic [DIST_W-1:0]    dist_add;
    logic [TIME_W-1:0]    late_full;
    logic [DIST_W-1:0]    late_clip;
    logic [DIST_W:0]      late_x;
    logic [DIST_W-1:0]    late_add;
    logic [DEM_W:0]       dem_x;
    logic [DEM_W-1:0]     dem_add;
    logic [TIME_W:0]      dep_x;
    logic [TIME_W-1:0]    dep;
    logic [CNT_W-1:0]     count_add;
    logic [CNT_W-1:0]     counted;
    logic [CNT_W-1:0]     customers;
    logic                 short_route;
    logic                 over;
    logic                 out_free;
    logic                 sum_done;
    logic                 result_load;

    assign ready_fx = TIME_W'(stop_reg.ready_time) << FRAC_BITS;
    assign due_fx   = TIME_W'(stop_reg.due_time) << FRAC_BITS;
    assign serv_fx  = TIME_W'(stop_reg.service_duration) << FRAC_BITS;

    // arrival and start of service
    assign arrive_x   = {1'b0, prev_dep_reg} + TIME_X_W'(leg_reg);
    assign arrive     = arrive_x[TIME_W] ? '1 : arrive_x[TIME_W-1:0];
    assign start_calc = (stop_reg.first || (ready_fx >= arrive)) ? ready_fx : arrive;

    assign dist_x   = {1'b0, dist_sum_reg} + DIST_X_W'(leg_reg);
    assign dist_add = dist_x[DIST_W] ? '1 : dist_x[DIST_W-1:0];

    // lateness past the due time, clipped before the saturating add
    assign late_full = (start_reg > due_fx) ? (start_reg - due_fx) : '0;
    assign late_clip = (|late_full[TIME_W-1:DIST_W]) ? '1 : late_full[DIST_W-1:0];
    assign late_x    = {1'b0, late_sum_reg} + {1'b0, late_clip};
    assign late_add  = late_x[DIST_W] ? '1 : late_x[DIST_W-1:0];

    assign dem_x   = {1'b0, dem_sum_reg} + DEM_X_W'(stop_reg.demand);
    assign dem_add = dem_x[DEM_W] ? '1 : dem_x[DEM_W-1:0];

    assign dep_x = {1'b0, start_reg} + {1'b0, serv_fx};
    assign dep   = dep_x[TIME_W] ? '1 : dep_x[TIME_W-1:0];

    assign count_add   = (count_reg < CNT_W'(MAX_ROUTE_STOPS + 1)) ?
                         (count_reg + CNT_W'(1)) : count_reg;
    assign short_route = (count_add <= CNT_W'(rtwe_pkg::DEPOT_STOPS));
    assign over        = (count_add > CNT_W'(MAX_ROUTE_STOPS));
    assign counted     = over ? CNT_W'(MAX_ROUTE_STOPS) : count_add;
    assign customers   = counted - CNT_W'(rtwe_pkg::DEPOT_STOPS);

    assign out_free    = !out_valid_reg || !out_stall;
    assign sum_done    = (state_reg == B_SUM) && (!stop_reg.last || out_free);
    assign result_load = sum_done && stop_reg.last;
    assign q_pop       = (state_reg == B_IDLE) && !q_empty;

    assign out_valid      = out_valid_reg;
    assign route_length   = dist_out_reg;
    assign route_load     = dem_out_reg;
    assign route_lateness = late_out_reg;
    assign customer_count = cust_out_reg;
    assign route_overflow = over_out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_TIME;
                end
            end
            B_TIME:
            begin
                state_next = B_SUM;
            end
            B_SUM:
            begin
                if (sum_done)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            stop_reg <= item_stop;
            leg_reg  <= item_leg;
        end

        if (state_reg == B_TIME)
        begin
            start_reg <= start_calc;
            if (stop_reg.first)
            begin
                dist_sum_reg <= '0;
                dem_sum_reg  <= '0;
                late_sum_reg <= '0;
                count_reg    <= '0;
            end
            else
            begin
                dist_sum_reg <= dist_add;
            end
        end

        if (sum_done)
        begin
            dem_sum_reg  <= dem_add;
            late_sum_reg <= late_add;
            prev_dep_reg <= dep;
            count_reg    <= count_add;
        end

        if (result_load)
        begin
            if (short_route)
            begin
                dist_out_reg <= '0;
                dem_out_reg  <= '0;
                late_out_reg <= '0;
                cust_out_reg <= '0;
                over_out_reg <= 1'b0;
            end
            else
            begin
                dist_out_reg <= dist_sum_reg;
                dem_out_reg  <= dem_add;
                late_out_reg <= late_add;
                cust_out_reg <= COUNT_W'(customers);
                over_out_reg <= over;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/route_time_window_evaluator_unit.sv =====
// Route time-window evaluator: feed the stops of one vehicle route in order, one request per
// stop, with last_stop set on the final (return depot) stop; one result request follows each
// last stop with the route length, total demand, summed lateness past the due times (both
// fixed point with FRAC_BITS fraction bits), the customer count (stops minus two) and an
// overflow flag for routes longer than MAX_ROUTE_STOPS. Routes of fewer than three stops
// report all zeros, and all totals saturate. The front end passes the opening stop of a route
// straight to the queue and every later stop after the bit-serial square root of the leg
// length, which yields one root bit per cycle; it takes no new stop until the previous one
// is in the queue. The back end takes one stop at a time through its time and sum states. A
// two-entry queue decouples the stop front end from the time and sum back end, so a result
// held by out_stall holds up only the next last stop, and further stops are taken in until
// the queue and the front end behind it fill up.
`default_nettype none

module route_time_window_evaluator_unit #(
    parameter int MAX_ROUTE_STOPS = rtwe_pkg::MAX_ROUTE_STOPS_DEF,
    parameter int FRAC_BITS       = rtwe_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // stop requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rtwe_pkg::COORD_W-1:0]   x_coord,
    input  logic [rtwe_pkg::COORD_W-1:0]   y_coord,
    input  logic [rtwe_pkg::FIELD_W-1:0]   demand,
    input  logic [rtwe_pkg::FIELD_W-1:0]   ready_time,
    input  logic [rtwe_pkg::FIELD_W-1:0]   due_time,
    input  logic [rtwe_pkg::FIELD_W-1:0]   service_duration,
    input  logic                           last_stop,
    // route result requests
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rtwe_pkg::DIST_W-1:0]    route_length,
    output logic [rtwe_pkg::DEM_W-1:0]     route_load,
    output logic [rtwe_pkg::DIST_W-1:0]    route_lateness,
    output logic [rtwe_pkg::COUNT_W-1:0]   customer_count,
    output logic                           route_overflow
);

    localparam int LEG_W   = rtwe_pkg::LEG_INT_W + FRAC_BITS;
    localparam int STOP_W  = rtwe_pkg::STOP_W;
    localparam int ENTRY_W = LEG_W + STOP_W;
    localparam int COUNT_W = rtwe_pkg::COUNT_W;

    // front end to queue
    logic                  q_push;
    logic                  q_full;
    rtwe_pkg::stop_t       front_stop;
    logic [LEG_W-1:0]      front_leg;

    // queue to back end
    logic                  q_pop;
    logic                  q_empty;
    logic [ENTRY_W-1:0]    q_rd_data;
    rtwe_pkg::stop_t       back_stop;
    logic [LEG_W-1:0]      back_leg;

    assign back_stop = q_rd_data[STOP_W-1:0];
    assign back_leg  = q_rd_data[ENTRY_W-1:STOP_W];

    // front end: takes stops, tracks route start, computes the leg length
    rtwe_front #(
        .FRAC_BITS        (FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .demand           (demand),
        .ready_time       (ready_time),
        .due_time         (due_time),
        .service_duration (service_duration),
        .last_stop        (last_stop),
        .q_push           (q_push),
        .q_full           (q_full),
        .q_stop           (front_stop),
        .q_leg            (front_leg)
    );

    // short queue of classified stops with their leg lengths
    rtwe_fifo #(
        .DATA_W  (ENTRY_W),
        .DEPTH   (rtwe_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data ({front_leg, front_stop}),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // back end: arrival, start, lateness, sums and the result register
    rtwe_back #(
        .MAX_ROUTE_STOPS (MAX_ROUTE_STOPS),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .item_stop       (back_stop),
        .item_leg        (back_leg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .route_length    (route_length),
        .route_load      (route_load),
        .route_lateness  (route_lateness),
        .customer_count  (customer_count),
        .route_overflow  (route_overflow)
    );

`ifndef SYNTHESIS
    // the front end never writes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("stop written into full queue");

    // the back end never reads an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("stop read from empty queue");

    // an overlong route reports the capped customer count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && route_overflow) |->
            (customer_count == COUNT_W'(MAX_ROUTE_STOPS - rtwe_pkg::DEPOT_STOPS)))
        else $error("overflowed route with wrong customer count");

    // no customers only for a short route, which reports all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (customer_count == '0)) |->
            ((route_length == '0) && (route_load == '0) &&
             (route_lateness == '0) && !route_overflow))
        else $error("short route result not cleared");
`endif

endmodule

`default_nettype wire
